@@ src/vref_pkg.sv @@
// types and constants shared by the event fifo controller and datapath
// no dependencies
package vref_pkg;

  localparam logic [2:0] CMD_ENQ_TRY  = 3'd0;
  localparam logic [2:0] CMD_ENQ_OVR  = 3'd1;
  localparam logic [2:0] CMD_DEQUEUE  = 3'd2;
  localparam logic [2:0] CMD_PEEK     = 3'd3;
  localparam logic [2:0] CMD_FLUSH    = 3'd4;

  localparam logic [1:0] REG_QUEUE_SIZE = 2'd0;
  localparam logic [1:0] REG_LOW_WATER  = 2'd1;
  localparam logic [1:0] REG_HIGH_WATER = 2'd2;

  localparam logic [2:0] LVL_EMPTY  = 3'd0;
  localparam logic [2:0] LVL_LOW    = 3'd1;
  localparam logic [2:0] LVL_MEDIUM = 3'd2;
  localparam logic [2:0] LVL_HIGH   = 3'd3;
  localparam logic [2:0] LVL_FULL   = 3'd4;

  // store depth; the 11-bit count and config ports are sized for it
  localparam int unsigned QUEUE_DEPTH = 1024;

  localparam int unsigned MAX_RECORD_WORDS = 3;
  localparam logic [7:0] EOQ_CODE     = 8'd255;
  localparam logic [7:0] OVERRUN_CODE = 8'd252;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PUSH,
    ST_PULL_REQ,
    ST_PULL_WAIT,
    ST_MARK,
    ST_PEEK_REQ,
    ST_PEEK_WAIT,
    ST_STATUS,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic decide;     // evaluate enqueue room / dequeue empty / peek depth
    logic push;       // write next staged word
    logic pull_req;   // issue store read at read pointer
    logic pull_take;  // consume read word
    logic mark;       // push overrun marker
    logic peek_req;   // issue store read at peek position
    logic peek_take;  // consume peek word
    logic flush;
    logic status;     // compute status fields
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_enq;
    logic is_deq;
    logic is_peek;
    logic is_flush;
    logic enq_ok;
    logic deq_empty;
    logic peek_eoq;
    logic push_last;
    logic pull_last;
    logic need_mark;
    logic peek_done;
  } sts_t;

endpackage

@@ src/vref_ctrl.sv @@
// controller state machine of the event fifo
// depends on vref_pkg
module vref_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vref_pkg::sts_t sts_i,
  output vref_pkg::ctl_t ctl_o
);

  vref_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vref_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      vref_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = vref_pkg::ST_DECIDE;
        end
      end
      vref_pkg::ST_DECIDE: begin
        ctl_o.decide = 1'b1;
        if (sts_i.is_enq) begin
          state_d = sts_i.enq_ok ? vref_pkg::ST_PUSH : vref_pkg::ST_STATUS;
        end else if (sts_i.is_deq) begin
          state_d = sts_i.deq_empty ? vref_pkg::ST_STATUS : vref_pkg::ST_PULL_REQ;
        end else if (sts_i.is_peek) begin
          state_d = sts_i.peek_eoq ? vref_pkg::ST_STATUS : vref_pkg::ST_PEEK_REQ;
        end else begin
          ctl_o.flush = sts_i.is_flush;
          state_d = vref_pkg::ST_STATUS;
        end
      end
      vref_pkg::ST_PUSH: begin
        ctl_o.push = 1'b1;
        if (sts_i.push_last) state_d = vref_pkg::ST_STATUS;
      end
      vref_pkg::ST_PULL_REQ: begin
        ctl_o.pull_req = 1'b1;
        state_d = vref_pkg::ST_PULL_WAIT;
      end
      vref_pkg::ST_PULL_WAIT: begin
        ctl_o.pull_take = 1'b1;
        if (!sts_i.pull_last) begin
          state_d = vref_pkg::ST_PULL_REQ;
        end else if (sts_i.need_mark) begin
          state_d = vref_pkg::ST_MARK;
        end else begin
          state_d = vref_pkg::ST_STATUS;
        end
      end
      vref_pkg::ST_MARK: begin
        ctl_o.mark = 1'b1;
        state_d = vref_pkg::ST_STATUS;
      end
      vref_pkg::ST_PEEK_REQ: begin
        ctl_o.peek_req = 1'b1;
        state_d = vref_pkg::ST_PEEK_WAIT;
      end
      vref_pkg::ST_PEEK_WAIT: begin
        ctl_o.peek_take = 1'b1;
        state_d = sts_i.peek_done ? vref_pkg::ST_STATUS : vref_pkg::ST_PEEK_REQ;
      end
      vref_pkg::ST_STATUS: begin
        ctl_o.status = 1'b1;
        state_d = vref_pkg::ST_OUT;
      end
      vref_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = vref_pkg::ST_IDLE;
      end
      default: state_d = vref_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ src/vref_dpath.sv @@
// datapath of the event fifo: word store, pointers, staging and status
// depends on vref_pkg
module vref_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vref_pkg::ctl_t ctl_i,
  output vref_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [10:0]    cfg_data_i,
  input  logic [2:0]     cmd_i,
  input  logic [7:0]     event_code_i,
  input  logic [31:0]    event_data_i,
  input  logic [10:0]    peek_depth_i,
  output logic           accepted_o,
  output logic           end_of_queue_o,
  output logic [7:0]     result_code_o,
  output logic [31:0]    result_data_o,
  output logic           data_valid_o,
  output logic [2:0]     fill_level_o,
  output logic [10:0]    word_count_o,
  output logic           overrun_flag_o,
  output logic [9:0]     enqueue_threshold_o,
  output logic [10:0]    dequeue_threshold_o
);

  localparam int unsigned QUEUE_DEPTH = vref_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned MIN_SIZE = 2 * vref_pkg::MAX_RECORD_WORDS;

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [15:0]   rd_q;
  logic [CW-1:0] size_q, held_q, wp_q, rp_q, pos_q, walked_q;
  logic          ovr_q;
  logic [9:0]    low_q, high_q;
  logic [2:0]    cmd_q;
  logic [7:0]    code_q;
  logic [31:0]   data_q;
  logic [10:0]   depth_q;
  logic [1:0]    cnt_q, need_q;
  logic [7:0]    first_q;
  logic [31:0]   d_q;
  logic          acc_q, eoq_q, dvalid_q;
  logic [7:0]    rcode_q;
  logic [31:0]   rdata_q;
  logic [15:0]   wword;
  logic [1:0]    rec_len;
  logic [CW-1:0] wp_inc, rp_inc, pos_nx, walked_nx, held_up;
  logic [CW:0]   pos_sum;
  logic          can_push;
  logic [10:0]   cfg_clamped;

  // command decode
  always_comb begin
    sts_o = '0;
    case (cmd_q)
      vref_pkg::CMD_ENQ_TRY, vref_pkg::CMD_ENQ_OVR: sts_o.is_enq = 1'b1;
      vref_pkg::CMD_DEQUEUE: sts_o.is_deq = 1'b1;
      vref_pkg::CMD_PEEK:    sts_o.is_peek = 1'b1;
      vref_pkg::CMD_FLUSH:   sts_o.is_flush = 1'b1;
      default: ;
    endcase
    sts_o.enq_ok    = !ovr_q && ((size_q - held_q) >= CW'(need_q));
    sts_o.deq_empty = (held_q == '0);
    sts_o.peek_eoq  = (CW'(depth_q) >= held_q);
    sts_o.push_last = (cnt_q + 2'd1 >= need_q);
    sts_o.pull_last = (cnt_q == 2'd0) ? ((rd_q[1:0] < 2'd2) || held_q == '0)
                                      : ((cnt_q + 2'd1 >= need_q) || held_q == '0);
    sts_o.need_mark = ovr_q;
    sts_o.peek_done = (depth_q == '0) || (walked_nx >= held_q);
  end

  // record length from the current store word
  assign rec_len = (rd_q[1:0] == 2'd0) ? 2'd1 : rd_q[1:0];

  // staged word for enqueue
  always_comb begin
    case (cnt_q)
      2'd0:    wword = {data_q[7:0], code_q};
      2'd1:    wword = data_q[15:0];
      default: wword = data_q[31:16];
    endcase
  end

  assign can_push  = (held_q < size_q);
  assign wp_inc    = (wp_q + 1'b1 >= size_q) ? '0 : wp_q + 1'b1;
  assign rp_inc    = (rp_q + 1'b1 >= size_q) ? '0 : rp_q + 1'b1;
  assign pos_sum   = {1'b0, pos_q} + (CW + 1)'(rec_len);
  assign pos_nx    = (pos_sum >= {1'b0, size_q}) ? CW'(pos_sum - {1'b0, size_q})
                                                 : CW'(pos_sum);
  assign walked_nx = walked_q + CW'(rec_len);
  assign held_up   = held_q + 1'b1;

  // queue_size clamp
  always_comb begin
    if (cfg_data_i < 11'(MIN_SIZE))                 cfg_clamped = 11'(MIN_SIZE);
    else if ({1'b0, cfg_data_i} > 12'(QUEUE_DEPTH)) cfg_clamped = 11'(QUEUE_DEPTH);
    else                                            cfg_clamped = cfg_data_i;
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && can_push) mem[wp_q[AW-1:0]] <= wword;
    else if (ctl_i.mark && can_push) mem[wp_q[AW-1:0]] <= {8'd0, vref_pkg::OVERRUN_CODE};
    if (ctl_i.pull_req) rd_q <= mem[rp_q[AW-1:0]];
    else if (ctl_i.peek_req) rd_q <= mem[pos_q[AW-1:0]];
  end

  // control state: pointers, counts, registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CW'(QUEUE_DEPTH);
      low_q  <= 10'd341;
      high_q <= 10'd682;
      held_q <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
      ovr_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vref_pkg::REG_QUEUE_SIZE: begin
            size_q <= CW'(cfg_clamped);
            held_q <= '0;
            wp_q   <= '0;
            rp_q   <= '0;
            ovr_q  <= 1'b0;
          end
          vref_pkg::REG_LOW_WATER:  low_q  <= cfg_data_i[9:0];
          vref_pkg::REG_HIGH_WATER: high_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (ctl_i.flush) begin
        held_q <= '0;
        wp_q   <= '0;
        rp_q   <= '0;
        ovr_q  <= 1'b0;
      end
      if (ctl_i.decide && sts_o.is_enq && cmd_q == vref_pkg::CMD_ENQ_OVR) begin
        ovr_q <= !sts_o.enq_ok;
      end
      if ((ctl_i.push || ctl_i.mark) && can_push) begin
        wp_q   <= wp_inc;
        held_q <= held_up;
      end
      if (ctl_i.mark) ovr_q <= 1'b0;
      if (ctl_i.pull_take && held_q != '0) begin
        rp_q   <= rp_inc;
        held_q <= held_q - 1'b1;
      end
    end
  end

  // beat capture and per-item work registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= cmd_i;
      code_q   <= event_code_i;
      data_q   <= event_data_i;
      depth_q  <= peek_depth_i;
      need_q   <= (event_code_i[1:0] == 2'd0) ? 2'd1 : event_code_i[1:0];
      cnt_q    <= '0;
      acc_q    <= 1'b0;
      eoq_q    <= 1'b0;
      rcode_q  <= '0;
      rdata_q  <= '0;
      dvalid_q <= 1'b0;
      d_q      <= '0;
      first_q  <= '0;
    end
    if (ctl_i.decide) begin
      cnt_q    <= '0;
      pos_q    <= rp_q;
      walked_q <= '0;
      if (sts_o.is_enq) acc_q <= sts_o.enq_ok;
      if ((sts_o.is_deq && sts_o.deq_empty) || (sts_o.is_peek && sts_o.peek_eoq)) begin
        eoq_q   <= 1'b1;
        rcode_q <= vref_pkg::EOQ_CODE;
      end
    end
    if (ctl_i.push) cnt_q <= cnt_q + 2'd1;
    if (ctl_i.pull_take) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd0) begin
        first_q  <= rd_q[7:0];
        need_q   <= rd_q[1:0];
        d_q      <= {24'd0, rd_q[15:8]};
        rcode_q  <= rd_q[7:0];
        dvalid_q <= (rd_q[1:0] != 2'd0);
      end else if (cnt_q == 2'd1) begin
        d_q <= {16'd0, (held_q != '0) ? rd_q : 16'd0};
      end else begin
        d_q <= {(held_q != '0) ? rd_q : 16'd0, d_q[15:0]};
      end
    end
    if (ctl_i.peek_take) begin
      if (depth_q == '0) begin
        rcode_q <= rd_q[7:0];
      end else begin
        depth_q  <= depth_q - 11'd1;
        walked_q <= walked_nx;
        pos_q    <= pos_nx;
        if (walked_nx >= held_q) begin
          eoq_q   <= 1'b1;
          rcode_q <= vref_pkg::EOQ_CODE;
        end
      end
    end
    if (ctl_i.status) begin
      if (sts_o.is_deq && !eoq_q && first_q[1:0] != 2'd0) rdata_q <= d_q;
    end
  end

  assign accepted_o     = acc_q;
  assign end_of_queue_o = eoq_q;
  assign result_code_o  = rcode_q;
  assign result_data_o  = rdata_q;
  assign data_valid_o   = dvalid_q;

  // status fields from held words and thresholds
  always_comb begin
    word_count_o   = 11'(held_q);
    overrun_flag_o = ovr_q;
    if (held_q < CW'(low_q)) begin
      dequeue_threshold_o = 11'd1;
      if (held_q == '0) begin
        fill_level_o = vref_pkg::LVL_EMPTY;
        enqueue_threshold_o = '0;
      end else begin
        fill_level_o = vref_pkg::LVL_LOW;
        enqueue_threshold_o = low_q - 10'd1;
      end
    end else if (held_q > CW'(high_q)) begin
      enqueue_threshold_o = 10'(size_q - CW'(vref_pkg::MAX_RECORD_WORDS));
      if (!ovr_q && held_q < size_q) begin
        fill_level_o = vref_pkg::LVL_HIGH;
        dequeue_threshold_o = {1'b0, high_q};
      end else begin
        fill_level_o = vref_pkg::LVL_FULL;
        dequeue_threshold_o = 11'(held_q);
      end
    end else begin
      fill_level_o = vref_pkg::LVL_MEDIUM;
      enqueue_threshold_o = high_q - 10'd1;
      dequeue_threshold_o = {1'b0, low_q};
    end
  end

endmodule

@@ src/variable_record_event_fifo.sv @@
// event fifo top: controller and datapath with valid/ready channels, depends on vref_pkg
// straight to status: flush, unused commands, refused enqueue, empty dequeue
// and peek past end; enqueue writes each record word to the store, dequeue reads each
// word and may push an overrun marker, peek reads one store word per record visited
// throughput: one beat at a time, next beat taken the cycle after the result is taken
// reset clears pointers, counts, overrun and state; store contents are left undefined
module variable_record_event_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  event_code_i,
  input  logic [31:0] event_data_i,
  input  logic [10:0] peek_depth_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic        end_of_queue_o,
  output logic [7:0]  result_code_o,
  output logic [31:0] result_data_o,
  output logic        data_valid_o,
  output logic [2:0]  fill_level_o,
  output logic [10:0] word_count_o,
  output logic        overrun_flag_o,
  output logic [9:0]  enqueue_threshold_o,
  output logic [10:0] dequeue_threshold_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  vref_pkg::ctl_t ctl;
  vref_pkg::sts_t sts;

  vref_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  vref_dpath u_dpath (
    .clk_i, .rst_ni,
    .ctl_i              (ctl),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd_i),
    .event_code_i       (event_code_i),
    .event_data_i       (event_data_i),
    .peek_depth_i       (peek_depth_i),
    .accepted_o         (accepted_o),
    .end_of_queue_o     (end_of_queue_o),
    .result_code_o      (result_code_o),
    .result_data_o      (result_data_o),
    .data_valid_o       (data_valid_o),
    .fill_level_o       (fill_level_o),
    .word_count_o       (word_count_o),
    .overrun_flag_o     (overrun_flag_o),
    .enqueue_threshold_o(enqueue_threshold_o),
    .dequeue_threshold_o(dequeue_threshold_o)
  );

endmodule
